// ----- rtl/smpq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types, constants and the note value table for the scale-mask
// pitch quantizer.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int NOTE_COUNT = 12;
    localparam int PITCH_W    = 21;
    localparam int FRAC_W     = 16;
    localparam int OCT_W      = PITCH_W - FRAC_W;
    localparam int POS_W      = 20;
    localparam int IDX_W      = 4;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_in;
        logic [NOTE_COUNT-1:0]     button_levels;
    } t_in_item;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_out;
        logic [NOTE_COUNT-1:0]     note_lights;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic [OCT_W-1:0]      octave;
        logic [FRAC_W-1:0]     frac;
        logic [NOTE_COUNT-1:0] enable;
    } t_work_item;

    typedef struct packed {
        logic [POS_W-1:0] distance;
        logic [IDX_W-1:0] idx;
    } t_cand;

    // 65536 * note / 12, rounded to nearest
    function automatic logic [FRAC_W-1:0] note_value(input logic [IDX_W-1:0] idx);
        logic [FRAC_W-1:0] v;
        case (idx)
            4'd0:    v = 16'd0;
            4'd1:    v = 16'd5461;
            4'd2:    v = 16'd10923;
            4'd3:    v = 16'd16384;
            4'd4:    v = 16'd21845;
            4'd5:    v = 16'd27307;
            4'd6:    v = 16'd32768;
            4'd7:    v = 16'd38229;
            4'd8:    v = 16'd43691;
            4'd9:    v = 16'd49152;
            4'd10:   v = 16'd54613;
            4'd11:   v = 16'd60075;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // right side wins only when strictly nearer, so the lower index keeps ties
    function automatic t_cand pick(input t_cand a, input t_cand b);
        t_cand r;
        if (b.distance < a.distance) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/smpq_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_front
// Accepts input items, detects button edges, toggles the note enables and
// splits the pitch into octave and fraction for the back end.
// ----------------------------------------------------------------------------
module smpq_front
    import smpq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    output logic            o_push,
    output t_work_item      o_push_item,
    input  wire logic       i_push_ready
);

    logic [NOTE_COUNT-1:0] r_note_enable;
    logic [NOTE_COUNT-1:0] n_note_enable;
    logic [NOTE_COUNT-1:0] r_button_previous;
    logic [NOTE_COUNT-1:0] w_rising;

    assign o_in_ready    = i_push_ready;
    assign o_push        = i_in_valid && i_push_ready;
    assign w_rising      = i_in_item.button_levels & ~r_button_previous;
    assign n_note_enable = r_note_enable ^ w_rising;

    // arithmetic floor by 65536 is just the top bits
    assign o_push_item.octave = i_in_item.pitch_in[PITCH_W-1:FRAC_W];
    assign o_push_item.frac   = i_in_item.pitch_in[FRAC_W-1:0];
    assign o_push_item.enable = n_note_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_enable     <= '0;
            r_button_previous <= '0;
        end else if (o_push) begin
            r_note_enable     <= n_note_enable;
            r_button_previous <= i_in_item.button_levels;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/smpq_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_fifo
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module smpq_fifo
    import smpq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_work_item i_push_item,
    output logic            o_push_ready,
    input  wire logic       i_pop,
    output logic            o_pop_valid,
    output t_work_item      o_pop_item
);

    t_work_item            r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_push_ready = (r_count != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/smpq_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smpq_back
// Picks the nearest enabled note through twelve parallel distances and a
// compare tree, and holds the result in the output register.
// ----------------------------------------------------------------------------
module smpq_back
    import smpq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_pop_valid,
    input  wire t_work_item i_pop_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item
);

    logic [POS_W-1:0] w_position;
    t_cand            w_l0 [NOTE_COUNT];
    t_cand            w_l1 [6];
    t_cand            w_l2 [3];
    t_cand            w_l3;
    t_cand            w_best;
    logic             r_out_valid;
    t_out_item        r_out_item;

    // frac * 12 as two shifts
    assign w_position = {1'b0, i_pop_item.frac, 3'b000} + {2'b00, i_pop_item.frac, 2'b00};

    always_comb begin
        for (int i = 0; i < NOTE_COUNT; i++) begin
            logic [POS_W-1:0] target;
            target = {IDX_W'(i), {FRAC_W{1'b0}}};
            w_l0[i].idx = IDX_W'(i);
            if (!i_pop_item.enable[i]) begin
                // all equal when nothing is enabled, so note 0 wins
                w_l0[i].distance = '1;
            end else if (target >= w_position) begin
                w_l0[i].distance = target - w_position;
            end else begin
                w_l0[i].distance = w_position - target;
            end
        end
        for (int j = 0; j < 6; j++) begin
            w_l1[j] = pick(w_l0[2*j], w_l0[2*j+1]);
        end
        for (int k = 0; k < 3; k++) begin
            w_l2[k] = pick(w_l1[2*k], w_l1[2*k+1]);
        end
        w_l3   = pick(w_l2[0], w_l2[1]);
        w_best = pick(w_l3, w_l2[2]);
    end

    assign o_pop       = i_pop_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item.pitch_out   <= {i_pop_item.octave, note_value(w_best.idx)};
            r_out_item.note_lights <= i_pop_item.enable;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/scale_mask_pitch_quantizer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scale_mask_pitch_quantizer_top
// Twelve-tone pitch quantizer with a toggleable scale mask.
// ----------------------------------------------------------------------------
// Takes requests and returns one result per request in order.
// The front end updates the note mask from button edges as each request is
// accepted; a two-entry queue feeds the back end, whose twelve distance
// units and compare tree choose the note combinationally into the output
// register. Each result is registered in the queue and then in the output
// register, and with the output side ready the sustained rate is one
// request per cycle. The button edge memory and note mask reset to all clear.
module scale_mask_pitch_quantizer_top
    import smpq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    logic       w_push;
    logic       w_push_ready;
    t_work_item w_push_item;
    logic       w_pop;
    logic       w_pop_valid;
    t_work_item w_pop_item;

    smpq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push       (w_push),
        .o_push_item  (w_push_item),
        .i_push_ready (w_push_ready)
    );

    smpq_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_item  (w_push_item),
        .o_push_ready (w_push_ready),
        .i_pop        (w_pop),
        .o_pop_valid  (w_pop_valid),
        .o_pop_item   (w_pop_item)
    );

    smpq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_item  (w_pop_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_pop_valid)
        else $error("queue popped while empty");

    a_empty_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_valid && !o_out_valid) |-> w_pop)
        else $error("back end idles with an item queued and output free");

    a_pop_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_out_valid)
        else $error("popped item did not reach the output register");

    a_accept_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> w_push)
        else $error("accepted request not written to the queue");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scale-mask pitch quantizer. A queue of pitch
// requests (directed corner cases, then random streams with sparse button
// activity) feeds a valid/ready driver; a monitor predicts each quantized
// pitch and lights word on acceptance and compares results in order.
// ----------------------------------------------------------------------------
module tb_top;
    import smpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQS = 1830;
    localparam int QUIET_TAIL  = 150;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    scale_mask_pitch_quantizer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    t_in_item  pitch_requests[$];
    t_out_item expected_quantized[$];

    // predictor state
    logic [NOTE_COUNT-1:0] note_mask = '0;
    logic [NOTE_COUNT-1:0] button_prev = '0;

    int  total_reqs = 0;
    int  sent_cnt = 0;
    int  accepted_cnt = 0;
    int  err_count = 0;
    int  cycle_count = 0;
    logic in_taken = 1'b0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic quantize_pitch(input t_in_item req, output t_out_item res);
        logic [NOTE_COUNT-1:0] rising;
        logic signed [OCT_W-1:0] octave;
        logic [FRAC_W-1:0] frac;
        logic [19:0] position;
        logic [19:0] target;
        logic [19:0] note_dist;
        logic [19:0] best_dist;
        logic [FRAC_W-1:0] note_val;
        int best;
        int sum;
        rising = req.button_levels & ~button_prev;
        note_mask = note_mask ^ rising;
        button_prev = req.button_levels;
        // top bits of a two's complement value are already the floor
        octave = req.pitch_in[PITCH_W-1:FRAC_W];
        frac = req.pitch_in[FRAC_W-1:0];
        position = 20'(frac) * 20'd12;
        best_dist = 20'(NOTE_COUNT) << FRAC_W;
        best = 0;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            if (note_mask[i]) begin
                target = 20'(i) << FRAC_W;
                note_dist = (target >= position) ? target - position : position - target;
                if (note_dist < best_dist) begin
                    best_dist = note_dist;
                    best = i;
                end
            end
        end
        note_val = 16'((16384 * best + 1) / 3);
        sum = int'(octave) * 65536 + int'(note_val);
        res.pitch_out = sum[PITCH_W-1:0];
        res.note_lights = note_mask;
    endtask

    task automatic add_request(input int pitch, input logic [NOTE_COUNT-1:0] buttons);
        t_in_item req;
        req.pitch_in = pitch[PITCH_W-1:0];
        req.button_levels = buttons;
        pitch_requests.push_back(req);
    endtask

    // driver: new request at the falling edge, held until accepted
    always @(negedge i_clk) begin : req_driver
        int gap_left;
        bit idle_ok;
        if (i_rst_n) begin
            idle_ok = (sent_cnt < total_reqs - QUIET_TAIL) && ((sent_cnt / 300) % 4 != 3);
            if (i_in_valid && !in_taken) begin
                // still waiting for ready
            end else if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pitch_requests.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(1, 16) - 1;
                i_in_valid <= 1'b0;
            end else begin
                i_in_item <= pitch_requests.pop_front();
                i_in_valid <= 1'b1;
                sent_cnt++;
            end
        end
    end

    // receiver: random stalls, one long hold-off so the input side backs up
    always @(negedge i_clk) begin : result_sink
        int stall_left;
        bit hold_done;
        bit idle_ok;
        idle_ok = (accepted_cnt < total_reqs - QUIET_TAIL) && ((accepted_cnt / 256) % 3 != 2);
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (idle_ok && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: check the result first, then predict the newly accepted request
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = o_out_item;
                if (expected_quantized.size() == 0) begin
                    err_count++;
                    $display("%0t: result with nothing expected: pitch_out %h lights %h",
                             $realtime, got.pitch_out, got.note_lights);
                end else begin
                    want = expected_quantized.pop_front();
                    if (got.pitch_out !== want.pitch_out) begin
                        err_count++;
                        $display("%0t: pitch_out mismatch: expected %h actual %h",
                                 $realtime, want.pitch_out, got.pitch_out);
                    end
                    if (got.note_lights !== want.note_lights) begin
                        err_count++;
                        $display("%0t: note_lights mismatch: expected %h actual %h",
                                 $realtime, want.note_lights, got.note_lights);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                quantize_pitch(i_in_item, want);
                expected_quantized.push_back(want);
                accepted_cnt++;
            end
        end
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
    end

    initial begin : timeout
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [NOTE_COUNT-1:0] levels;
        int sel;
        int pitch;
        int oct;
        // button held through reset toggles note 11 on the first request
        add_request(24000, 12'h800);
        add_request(-655360, 12'h000);
        add_request(655360, 12'h000);
        add_request(-1048576, 12'h000);
        add_request(1048575, 12'h000);
        // note 11 off again, nothing enabled
        add_request(0, 12'h800);
        add_request(196607, 12'h000);
        // notes 0 and 3, then exact midpoint ties
        add_request(-1, 12'h009);
        add_request(8192, 12'h000);
        add_request(-57344, 12'h000);
        add_request(24576, 12'h048);
        add_request(65535, 12'h000);
        // only note 0 left, fraction just under one octave stays in octave
        add_request(65535, 12'h040);
        add_request(-1, 12'h040);
        add_request(32768, 12'hfff);
        add_request(98304, 12'h000);
        add_request(0, 12'hfff);
        add_request(-32768, 12'h000);
        add_request(0, 12'haaa);
        add_request(5461 * 3, 12'h555);
        for (int k = 0; k < 4; k++) begin
            add_request(k * 16384 + 2730, 12'h000);
        end
        levels = '0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
                levels = levels ^ (12'd1 << $urandom_range(0, NOTE_COUNT - 1));
            end else if (sel < 20) begin
                levels = 12'($urandom);
            end else if (sel < 23) begin
                levels = '0;
            end
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                pitch = int'($urandom_range(0, 1310720)) - 655360;
            end else if (sel < 8) begin
                // near a note center
                oct = int'($urandom_range(0, 20)) - 10;
                pitch = oct * 65536 + int'($urandom_range(0, 11)) * 5461
                        + int'($urandom_range(0, 8)) - 4;
            end else begin
                pitch = int'($urandom);
            end
            add_request(pitch, levels);
        end
        total_reqs = pitch_requests.size();
        @(posedge i_clk);
        while (pitch_requests.size() != 0 || i_in_valid || expected_quantized.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
